/* rtl/core/ntca_pkg.sv */
package ntca_pkg;

    // Parameter defaults
    localparam int MAX_CENTROIDS_DEF = 16;
    localparam int MAX_DIM_DEF       = 64;

    // Field and datapath widths
    localparam int VAL_W      = 16;
    localparam int CIDX_W     = 4;
    localparam int EIDX_W     = 6;
    localparam int IDX_OUT_W  = 4;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int ACC_W      = 40;
    localparam int ROOT_W     = ACC_W / 2;
    localparam int COS_FRAC   = 16;
    localparam int DIVD_W     = ACC_W + COS_FRAC;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METRIC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 1'b1;

    // Commands and metric codes
    localparam logic CMD_WRITE      = 1'b0;
    localparam logic CMD_POINT      = 1'b1;
    localparam logic METRIC_EUCLID  = 1'b0;
    localparam logic METRIC_COSINE  = 1'b1;

    // Cosine distance constants (Q2.16)
    localparam logic [ACC_W-1:0] COS_ONE   = ACC_W'(65536);
    localparam logic [ACC_W-1:0] COS_WORST = ACC_W'(262143);

    typedef struct packed {
        logic                    command;
        logic [CIDX_W-1:0]       centroid_index;
        logic [EIDX_W-1:0]       element_index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] nearest;
        logic [IDX_OUT_W-1:0] second_nearest;
    } result_t;

    typedef struct packed {
        logic [ACC_W-1:0]        dsq;
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        cn;
        logic                    eq;
    } acc_t;

    localparam acc_t ACC_RESET = '{dsq: '0, dot: '0, cn: '0, eq: 1'b1};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_DRAIN,
        ST_FIN,
        ST_PSQRT,
        ST_READ,
        ST_EVAL,
        ST_CSQRT,
        ST_MUL,
        ST_DIV,
        ST_CMP,
        ST_OUT
    } state_t;

endpackage

/* rtl/core/nearest_two_centroid_assign.sv */
// Centroid write: one transaction per cycle while idle. Point element: a pass over all MAX_CENTROIDS,
// one centroid a cycle through the accumulator memory's separate read and write ports.
// Last element adds the ranking pass over the centroids in use; for cosine it first takes
// the point root, then a 20-step root and a 56-step divider for each centroid that needs them.
// The result is registered in the output state once the result register is free.
// Reset (rst_n, async, low) sets metric to euclidean and count to 2, clears accumulators and handshakes.
module nearest_two_centroid_assign
    import ntca_pkg::*;
#(
    parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
    parameter int MAX_DIM       = MAX_DIM_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(MAX_CENTROIDS);
    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ECW   = $clog2(MAX_DIM + 1);
    localparam int NW    = $clog2(MAX_CENTROIDS + 1);
    localparam int AW    = CW + DW;
    localparam int DEPTH = 2 ** AW;
    localparam int PW    = 2 * VAL_W;
    localparam int SIM_W = COS_FRAC + 1;

    // Saturating adds for the 40-bit accumulators
    function automatic logic [ACC_W-1:0] sat_u(input logic [ACC_W:0] s);
        logic [ACC_W-1:0] r;
        r = s[ACC_W] ? '1 : s[ACC_W-1:0];
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] sat_s(input logic [ACC_W:0] s);
        logic [ACC_W-1:0] r;
        if (s[ACC_W] != s[ACC_W-1])
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            r = s[ACC_W-1:0];
        return r;
    endfunction

    state_t state_reg, state_next;

    logic                    metric_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [ECW-1:0]          ec_reg;
    logic [ACC_W-1:0]        pn_reg;
    logic [MAX_CENTROIDS-1:0] acc_vld_reg;
    logic [CW-1:0]           c_reg;
    logic                    p1_vld_reg;
    logic                    p2_vld_reg;
    logic                    res_valid_reg;
    result_t                 result_reg;

    // Per-element payload
    logic signed [VAL_W-1:0] v_reg;
    logic [DW-1:0]           e_reg;
    logic                    last_reg;

    // Centroid store and accumulator memory
    logic [VAL_W-1:0]        store_mem [DEPTH];
    logic [VAL_W-1:0]        store_q_reg;
    acc_t                    acc_mem [MAX_CENTROIDS];
    acc_t                    acc_q_reg;
    logic                    acc_qv_reg;

    // Update pipeline
    logic [CW-1:0]           p1_c_reg;
    logic [CW-1:0]           c2_reg;
    acc_t                    acc2_reg;
    logic [PW+1:0]           dsq_p_reg;
    logic signed [PW-1:0]    dot_p_reg;
    logic [PW-1:0]           cn_p_reg;
    logic                    eq2_reg;

    // Ranking
    logic [ROOT_W-1:0]       sp_reg;
    logic signed [ACC_W-1:0] dot_reg;
    logic [ACC_W-1:0]        den_reg;
    logic [ACC_W-1:0]        dist_reg;
    logic [CW-1:0]           best_reg;
    logic [ACC_W-1:0]        bd_reg;
    logic [CW-1:0]           sec_reg;
    logic [ACC_W-1:0]        sd_reg;
    logic                    secv_reg;

    logic                    item_acc;
    logic                    ec_full;
    logic                    st_we;
    logic [NW-1:0]           n_eff;
    logic                    fin_last;
    logic                    res_free;
    logic                    cos_go;
    acc_t                    acc_cur;
    acc_t                    acc_new;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W:0]   diff;
    logic signed [PW+1:0]    dsq_p;
    logic signed [PW-1:0]    dot_p;
    logic signed [PW-1:0]    cn_p;
    logic signed [PW-1:0]    vv_p;
    logic [ACC_W-1:0]        mag;
    logic [SIM_W-1:0]        qc;
    logic [ACC_W-1:0]        cos_dist;

    logic                    sq_start;
    logic [ACC_W-1:0]        sq_in;
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic                    dv_start;
    logic                    dv_done;
    logic [DIVD_W-1:0]       dv_q;

    assign item_acc = item_valid && !item_stall;
    assign ec_full  = (ec_reg == ECW'(MAX_DIM));
    assign res_free = !res_valid_reg || !result_stall;

    // Drop centroid writes that fall outside the store
    assign st_we = item_acc && (item.command == CMD_WRITE)
                   && (32'(item.centroid_index) < MAX_CENTROIDS)
                   && (32'(item.element_index) < MAX_DIM);

    // Clamp the centroid count into 2..MAX_CENTROIDS
    always_comb
    begin
        if (count_reg < CNT_W'(2))
            n_eff = NW'(2);
        else if (32'(count_reg) > MAX_CENTROIDS)
            n_eff = NW'(MAX_CENTROIDS);
        else
            n_eff = NW'(count_reg);
    end

    assign fin_last = ((NW'(c_reg) + NW'(1)) == n_eff);

    // Entries not written since the last result read as cleared
    assign acc_cur = acc_qv_reg ? acc_q_reg : ACC_RESET;

    // Stage 1: products of the point element and the centroid element
    assign y     = signed'(store_q_reg);
    assign diff  = (VAL_W+1)'(v_reg) - (VAL_W+1)'(y);
    assign dsq_p = (PW+2)'(diff) * (PW+2)'(diff);
    assign dot_p = PW'(v_reg) * PW'(y);
    assign cn_p  = PW'(y) * PW'(y);
    assign vv_p  = PW'(item.value) * PW'(item.value);

    // Stage 2: saturating accumulate
    always_comb
    begin
        acc_new.dsq = sat_u({1'b0, acc2_reg.dsq} + (ACC_W+1)'(dsq_p_reg));
        acc_new.dot = sat_s((ACC_W+1)'(acc2_reg.dot) + (ACC_W+1)'(dot_p_reg));
        acc_new.cn  = sat_u({1'b0, acc2_reg.cn} + (ACC_W+1)'(cn_p_reg));
        acc_new.eq  = eq2_reg;
    end

    // Cosine: hold one exact dot, clamp similarity to one, then 1 - sim
    assign mag      = dot_reg[ACC_W-1] ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);
    assign qc       = (dv_q > DIVD_W'(COS_ONE)) ? SIM_W'(COS_ONE) : dv_q[SIM_W-1:0];
    assign cos_dist = dot_reg[ACC_W-1] ? (COS_ONE + ACC_W'(qc)) : (COS_ONE - ACC_W'(qc));

    // Equal vectors win over the zero norm case
    assign cos_go = (metric_reg == METRIC_COSINE) && !acc_cur.eq
                    && (pn_reg != '0) && (acc_cur.cn != '0);

    ntca_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    ntca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend ({mag, COS_FRAC'(0)}),
        .divisor  (den_reg),
        .done     (dv_done),
        .quotient (dv_q)
    );

    // Memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[{CW'(item.centroid_index), DW'(item.element_index)}] <= item.value;
        store_q_reg <= store_mem[{c_reg, e_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (p2_vld_reg)
            acc_mem[c2_reg] <= acc_new;
        acc_q_reg  <= acc_mem[c_reg];
        acc_qv_reg <= acc_vld_reg[c_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        sq_in      = pn_reg;
        dv_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.command == CMD_POINT))
                begin
                    if (!ec_full)
                        state_next = ST_PASS;
                    else if (item.last)
                        state_next = ST_FIN;
                end
            end
            ST_PASS:
            begin
                if (c_reg == CW'(MAX_CENTROIDS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!p1_vld_reg && !p2_vld_reg)
                    state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (metric_reg == METRIC_COSINE)
                begin
                    sq_start   = 1'b1;
                    state_next = ST_PSQRT;
                end
                else
                    state_next = ST_READ;
            end
            ST_PSQRT:
            begin
                if (sq_done)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (cos_go)
                begin
                    sq_start   = 1'b1;
                    sq_in      = acc_cur.cn;
                    state_next = ST_CSQRT;
                end
                else
                    state_next = ST_CMP;
            end
            ST_CSQRT:
            begin
                if (sq_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                dv_start   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dv_done)
                    state_next = ST_CMP;
            end
            ST_CMP:
                state_next = fin_last ? ST_OUT : ST_READ;
            ST_OUT:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg    <= METRIC_EUCLID;
            count_reg     <= CNT_W'(2);
            ec_reg        <= '0;
            pn_reg        <= '0;
            acc_vld_reg   <= '0;
            c_reg         <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == REG_METRIC)
                    metric_reg <= cfg_data[0];
                else if (cfg_index == REG_COUNT)
                    count_reg <= cfg_data;
            end

            p1_vld_reg <= (state_reg == ST_PASS);
            p2_vld_reg <= p1_vld_reg;
            if (p2_vld_reg)
                acc_vld_reg[c2_reg] <= 1'b1;

            // Release the result register once the transaction is taken
            if (res_valid_reg && !result_stall && !((state_reg == ST_OUT) && res_free))
                res_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc && (item.command == CMD_POINT) && !ec_full)
                    begin
                        pn_reg <= sat_u({1'b0, pn_reg} + (ACC_W+1)'(unsigned'(vv_p)));
                        ec_reg <= ec_reg + ECW'(1);
                        c_reg  <= '0;
                    end
                end
                ST_PASS:
                    c_reg <= c_reg + CW'(1);
                ST_FIN:
                    c_reg <= '0;
                ST_CMP:
                begin
                    if (!fin_last)
                        c_reg <= c_reg + CW'(1);
                end
                ST_OUT:
                begin
                    if (res_free)
                    begin
                        res_valid_reg <= 1'b1;
                        ec_reg        <= '0;
                        pn_reg        <= '0;
                        acc_vld_reg   <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_acc && (item.command == CMD_POINT))
        begin
            v_reg    <= item.value;
            e_reg    <= DW'(ec_reg);
            last_reg <= item.last;
        end

        p1_c_reg  <= c_reg;
        c2_reg    <= p1_c_reg;
        acc2_reg  <= acc_cur;
        dsq_p_reg <= unsigned'(dsq_p);
        dot_p_reg <= dot_p;
        cn_p_reg  <= unsigned'(cn_p);
        eq2_reg   <= acc_cur.eq && (v_reg == y);

        if ((state_reg == ST_PSQRT) && sq_done)
            sp_reg <= sq_root;

        if (state_reg == ST_EVAL)
        begin
            dot_reg <= acc_cur.dot;
            if (metric_reg == METRIC_EUCLID)
                dist_reg <= acc_cur.dsq;
            else if (acc_cur.eq)
                dist_reg <= '0;
            else
                dist_reg <= COS_WORST;
        end

        if ((state_reg == ST_CSQRT) && sq_done)
            den_reg <= ACC_W'(sp_reg * sq_root);

        if ((state_reg == ST_DIV) && dv_done)
            dist_reg <= cos_dist;

        // Track best and runner-up in one sweep; strict compares keep low indexes
        if (state_reg == ST_CMP)
        begin
            if (c_reg == '0)
            begin
                best_reg <= c_reg;
                bd_reg   <= dist_reg;
                secv_reg <= 1'b0;
            end
            else if (dist_reg < bd_reg)
            begin
                sec_reg  <= best_reg;
                sd_reg   <= bd_reg;
                secv_reg <= 1'b1;
                best_reg <= c_reg;
                bd_reg   <= dist_reg;
            end
            else if (!secv_reg || (dist_reg < sd_reg))
            begin
                sec_reg  <= c_reg;
                sd_reg   <= dist_reg;
                secv_reg <= 1'b1;
            end
        end

        if ((state_reg == ST_OUT) && res_free)
        begin
            result_reg.nearest        <= IDX_OUT_W'(best_reg);
            result_reg.second_nearest <= IDX_OUT_W'(sec_reg);
        end
    end

    // Accept only in idle; the result register parts the output side
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/core/ntca_isqrt.sv */
module ntca_isqrt
    import ntca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int SCNT_W = $clog2(ROOT_W);

    logic                busy_reg;
    logic                done_reg;
    logic [SCNT_W-1:0]   cnt_reg;
    logic [ACC_W-1:0]    x_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+3:0]   rem_sh;
    logic [ROOT_W+3:0]   trial;
    logic                ge;

    // One result bit per step: bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_reg, x_reg[ACC_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + SCNT_W'(1);
                if (cnt_reg == SCNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= x_reg << 2;
            rem_reg  <= ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/core/ntca_div.sv */
module ntca_div
    import ntca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [ACC_W-1:0]  divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int DCNT_W = $clog2(DIVD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DIVD_W-1:0]   q_reg;
    logic [ACC_W-1:0]    rem_reg;
    logic [ACC_W-1:0]    dvs_reg;
    logic [ACC_W:0]      rem_sh;
    logic                ge;

    // Restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, q_reg[DIVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? ACC_W'(rem_sh - {1'b0, dvs_reg}) : ACC_W'(rem_sh);
            q_reg   <= {q_reg[DIVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/core/ntca_checker.sv */
module ntca_checker
    import ntca_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input item_t                 item,
    input logic                  result_valid,
    input logic                  result_stall,
    input result_t               result
);

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    // Runner-up always differs from the winner
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.nearest != result.second_nearest))
        else $error("nearest equals second nearest");

    // Centroid writes never block the next transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.command == CMD_WRITE) |=> !item_stall)
        else $error("stall after centroid write");

endmodule

bind nearest_two_centroid_assign ntca_checker u_ntca_checker (.*);
